/* hw/rtl/cr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cr_pkg;

    localparam int POS_W      = 6;
    localparam int N_W        = 7;
    localparam int T_W        = 3;
    localparam int SUB_W      = T_W + 1;
    localparam int RANK_W     = 27;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam int MAX_POSITIONS_DEF = 64;
    localparam int MAX_SUBSET_DEF    = 6;

    localparam logic [N_W-1:0] PARAM_COUNT_RST = 7'd64;
    localparam logic [T_W-1:0] SUBSET_SIZE_RST = 3'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PARAM_COUNT = 1'b0,
        REG_SUBSET_SIZE = 1'b1
    } cr_reg_e;

    typedef enum logic [1:0] {
        STEP_WAIT,
        STEP_LOOP,
        STEP_FINISH,
        STEP_EMIT
    } cr_step_e;

    typedef enum logic [1:0] {
        COND_ITEM_VALID,
        COND_LOOP_DONE,
        COND_LAST,
        COND_OUT_FREE
    } cr_cond_e;

    typedef struct packed {
        logic     accept;
        logic     loop;
        logic     finish;
        logic     emit;
        cr_cond_e cond;
        cr_step_e on_true;
        cr_step_e on_false;
    } cr_uword_t;

    typedef struct packed {
        logic item_valid;
        logic loop_done;
        logic last;
        logic out_free;
    } cr_flags_t;

    typedef struct packed {
        logic accept;
        logic loop;
        logic finish;
        logic emit;
        logic cond_met;
    } cr_ctrl_t;

    // Width that holds n itself and every position.
    function automatic int cr_num_w(int max_pos);
        return ($clog2(max_pos + 1) > POS_W) ? $clog2(max_pos + 1) : POS_W + 1;
    endfunction

    function automatic int cr_lane_w(int max_subset);
        return ($clog2(max_subset) > 0) ? $clog2(max_subset) : 1;
    endfunction

    // The control program: one word per step.
    function automatic cr_uword_t cr_ucode(cr_step_e step);
        cr_uword_t w;
        unique case (step)
            STEP_WAIT:   w = '{accept: 1'b1, loop: 1'b0, finish: 1'b0, emit: 1'b0,
                               cond: COND_ITEM_VALID, on_true: STEP_LOOP,
                               on_false: STEP_WAIT};
            STEP_LOOP:   w = '{accept: 1'b0, loop: 1'b1, finish: 1'b0, emit: 1'b0,
                               cond: COND_LOOP_DONE, on_true: STEP_FINISH,
                               on_false: STEP_LOOP};
            STEP_FINISH: w = '{accept: 1'b0, loop: 1'b0, finish: 1'b1, emit: 1'b0,
                               cond: COND_LAST, on_true: STEP_EMIT,
                               on_false: STEP_WAIT};
            STEP_EMIT:   w = '{accept: 1'b0, loop: 1'b0, finish: 1'b0, emit: 1'b1,
                               cond: COND_OUT_FREE, on_true: STEP_WAIT,
                               on_false: STEP_EMIT};
            default:     w = '{accept: 1'b1, loop: 1'b0, finish: 1'b0, emit: 1'b0,
                               cond: COND_ITEM_VALID, on_true: STEP_LOOP,
                               on_false: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cr_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cr_item_if import cr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;

    modport source (output valid, output position, input ready);
    modport sink (input valid, input position, output ready);
endinterface

interface cr_result_if import cr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank;
    logic              order_error;

    modport source (output valid, output rank, output order_error, input ready);
    modport sink (input valid, input rank, input order_error, output ready);
endinterface

interface cr_cfg_if import cr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/combination_rank.sv */
// Lexicographic rank of a t-subset of the positions 0..n-1.
// The cfg channel writes n (index 0) and t (index 1); it is always ready; the
// user is to write it only while the block is idle, which the block itself
// does not enforce. The item channel carries one position per transfer, in
// ascending order; the t-th position of a subset completes it, and one
// transfer on the result channel then carries the rank and the order_error
// flag (rank reads 0 when the flag is set).
// A small control program steps a datapath that builds one row of Pascal's
// triangle per cycle. Each position walks b + 1 rows (b is n - 1 for the
// first element and at most n - 2 after; a position out of order walks one
// row), and a subset's last position then also loads the output register.
// The next position is accepted as soon as the previous one is done, while a
// result still waits in the output register. If the receiver stalls with a
// result pending, the next subset is still worked on, and only its
// completion waits for the register to drain.
// Reset clears the partial subset, the error flag and the output valid flag
// and sets n to 64 and t to 2.
`timescale 1ns / 1ps
`default_nettype none

module combination_rank import cr_pkg::*; #(
    parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
    parameter int MAX_SUBSET    = MAX_SUBSET_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cr_cfg_if.sink      cfg,
    cr_item_if.sink     item,
    cr_result_if.source result
);

    localparam int NW = cr_num_w(MAX_POSITIONS);
    localparam logic [N_W:0]     MAX_N_WIDE = (N_W + 1)'(MAX_POSITIONS);
    localparam logic [SUB_W-1:0] MAX_T      = SUB_W'(MAX_SUBSET);

    logic [N_W-1:0]   param_count_reg, param_count_next;
    logic [T_W-1:0]   subset_size_reg, subset_size_next;
    logic [NW-1:0]    n_eff;
    logic [SUB_W-1:0] t_eff;
    cr_flags_t        flags;
    cr_ctrl_t         ctrl;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        param_count_next = param_count_reg;
        subset_size_next = subset_size_reg;
        if (cfg.valid)
        begin
            unique case (cr_reg_e'(cfg.index))
                REG_PARAM_COUNT: param_count_next = cfg.data[N_W-1:0];
                REG_SUBSET_SIZE: subset_size_next = cfg.data[T_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            param_count_reg <= PARAM_COUNT_RST;
            subset_size_reg <= SUBSET_SIZE_RST;
        end
        else
        begin
            param_count_reg <= param_count_next;
            subset_size_reg <= subset_size_next;
        end
    end

    always_comb
    begin
        if ((N_W + 1)'(param_count_reg) > MAX_N_WIDE)
        begin
            n_eff = NW'(MAX_POSITIONS);
        end
        else
        begin
            n_eff = NW'(param_count_reg);
        end

        if (subset_size_reg == '0)
        begin
            t_eff = SUB_W'(1);
        end
        else if (SUB_W'(subset_size_reg) > MAX_T)
        begin
            t_eff = MAX_T;
        end
        else
        begin
            t_eff = SUB_W'(subset_size_reg);
        end
    end

    cr_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    cr_datapath #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .MAX_SUBSET    (MAX_SUBSET)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .n_eff  (n_eff),
        .t_eff  (t_eff),
        .ctrl   (ctrl),
        .flags  (flags),
        .item   (item),
        .result (result)
    );

endmodule

`default_nettype wire

/* hw/rtl/cr_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none

module cr_sequencer import cr_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cr_flags_t flags,
    output cr_ctrl_t       ctrl
);

    cr_step_e  step_reg;
    cr_step_e  step_next;
    cr_uword_t uword;
    logic      cond_met;

    assign uword = cr_ucode(step_reg);

    always_comb
    begin
        unique case (uword.cond)
            COND_ITEM_VALID: cond_met = flags.item_valid;
            COND_LOOP_DONE:  cond_met = flags.loop_done;
            COND_LAST:       cond_met = flags.last;
            COND_OUT_FREE:   cond_met = flags.out_free;
            default:         cond_met = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = cond_met ? uword.on_true : uword.on_false;
    end

    always_comb
    begin
        ctrl.accept   = uword.accept;
        ctrl.loop     = uword.loop;
        ctrl.finish   = uword.finish;
        ctrl.emit     = uword.emit;
        ctrl.cond_met = cond_met;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/cr_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module cr_datapath import cr_pkg::*; #(
    parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
    parameter int MAX_SUBSET    = MAX_SUBSET_DEF,
    localparam int NW = cr_num_w(MAX_POSITIONS)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [NW-1:0]   n_eff,
    input  wire logic [SUB_W-1:0] t_eff,
    input  wire cr_ctrl_t        ctrl,
    output cr_flags_t            flags,
    cr_item_if.sink              item,
    cr_result_if.source          result
);

    localparam int LW = cr_lane_w(MAX_SUBSET);

    logic [POS_W-1:0]  prev_reg, prev_next;
    logic [T_W-1:0]    count_reg, count_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic              err_reg, err_next;
    logic              out_valid_reg, out_valid_next;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [T_W-1:0]    count_plus_reg, count_plus_next;
    logic              bad_reg, bad_next;
    logic              last_reg, last_next;
    logic [NW-1:0]     hi_reg, hi_next;
    logic [NW-1:0]     lo_reg, lo_next;
    logic [NW-1:0]     x_reg, x_next;
    logic [LW-1:0]     m_reg, m_next;
    logic [RANK_W-1:0] row_reg [MAX_SUBSET];
    logic [RANK_W-1:0] row_next [MAX_SUBSET];
    logic [RANK_W-1:0] out_rank_reg, out_rank_next;
    logic              out_err_reg, out_err_next;

    logic [NW-1:0]    pos_ext;
    logic [NW-1:0]    prev_ext;
    logic [SUB_W-1:0] c_ext;
    logic [SUB_W-1:0] c_cl;
    logic             first;
    logic             bad;
    logic             take;
    logic             emit_fire;

    assign take      = ctrl.accept && item.valid;
    assign emit_fire = ctrl.emit && ctrl.cond_met;

    assign pos_ext  = NW'(item.position);
    assign prev_ext = NW'(prev_reg);
    assign c_ext    = SUB_W'(count_reg);
    assign c_cl     = (c_ext >= t_eff) ? t_eff - SUB_W'(1) : c_ext;
    assign first    = (c_cl == '0);
    assign bad      = (pos_ext >= n_eff) || (!first && (item.position <= prev_reg));

    assign item.ready         = ctrl.accept;
    assign result.valid       = out_valid_reg;
    assign result.rank        = out_rank_reg;
    assign result.order_error = out_err_reg;

    always_comb
    begin
        flags.item_valid = item.valid;
        flags.loop_done  = bad_reg || (x_reg == hi_reg);
        flags.last       = last_reg;
        flags.out_free   = !out_valid_reg || result.ready;
    end

    always_comb
    begin
        prev_next       = prev_reg;
        count_next      = count_reg;
        rank_next       = rank_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg;
        pos_next        = pos_reg;
        count_plus_next = count_plus_reg;
        bad_next        = bad_reg;
        last_next       = last_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        x_next          = x_reg;
        m_next          = m_reg;
        row_next        = row_reg;
        out_rank_next   = out_rank_reg;
        out_err_next    = out_err_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (take)
        begin
            pos_next        = item.position;
            count_plus_next = T_W'(c_cl + SUB_W'(1));
            bad_next        = bad;
            last_next       = ((c_cl + SUB_W'(1)) >= t_eff);
            hi_next         = first ? n_eff - NW'(1) : n_eff - prev_ext - NW'(2);
            lo_next         = n_eff - pos_ext;
            m_next          = LW'(t_eff - c_cl - SUB_W'(1));
            err_next        = err_reg || bad;
            x_next          = '0;
            row_next[0]     = RANK_W'(1);
            for (int i = 1; i < MAX_SUBSET; i++)
            begin
                row_next[i] = '0;
            end
        end

        // One row of Pascal's triangle per cycle; the entry of order m is
        // added once x has entered the gap.
        if (ctrl.loop)
        begin
            if (!bad_reg && (x_reg >= lo_reg))
            begin
                rank_next = rank_reg + row_reg[m_reg];
            end
            x_next      = x_reg + NW'(1);
            row_next[0] = RANK_W'(1);
            for (int i = 1; i < MAX_SUBSET; i++)
            begin
                row_next[i] = row_reg[i] + row_reg[i-1];
            end
        end

        if (ctrl.finish && !last_reg)
        begin
            count_next = count_plus_reg;
            prev_next  = pos_reg;
        end

        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            out_rank_next  = err_reg ? '0 : rank_reg;
            out_err_next   = err_reg;
            prev_next      = '0;
            count_next     = '0;
            rank_next      = '0;
            err_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            count_reg     <= '0;
            rank_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prev_reg      <= prev_next;
            count_reg     <= count_next;
            rank_reg      <= rank_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        count_plus_reg <= count_plus_next;
        bad_reg        <= bad_next;
        last_reg       <= last_next;
        hi_reg         <= hi_next;
        lo_reg         <= lo_next;
        x_reg          <= x_next;
        m_reg          <= m_next;
        row_reg        <= row_next;
        out_rank_reg   <= out_rank_next;
        out_err_reg    <= out_err_next;
    end

endmodule

`default_nettype wire

/* bench/combination_rank_test.sv */
`timescale 1ns / 1ps

module combination_rank_test;
    import cr_pkg::*;

    localparam int IDLE_PCT       = 30;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 2 * MAX_POSITIONS_DEF + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 420;
    localparam int NUM_DIRECTED   = 11;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              err;
    } rank_result_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic              typed;
        logic [RANK_W-1:0] rank;
        logic              err;
    } feed_item_t;

    typedef struct packed {
        logic [N_W-1:0]           n;
        logic [T_W-1:0]           t;
        logic [2:0]               len;
        logic [0:5][POS_W-1:0]    pos;
        logic                     typed;
        logic [RANK_W-1:0]        rank;
        logic                     err;
    } rank_case_t;

    // Rows with typed = 0 are checked against the predictor.
    rank_case_t directed_cases [NUM_DIRECTED] = '{
        '{7'd64,  3'd2, 3'd2, '{6'd0, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b1, 27'd0, 1'b0},
        '{7'd64,  3'd2, 3'd2, '{6'd62, 6'd63, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b1, 27'd2015, 1'b0},
        '{7'd64,  3'd2, 3'd2, '{6'd5, 6'd5, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b1, 27'd0, 1'b1},
        '{7'd64,  3'd1, 3'd1, '{6'd63, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b1, 27'd63, 1'b0},
        '{7'd127, 3'd1, 3'd1, '{6'd63, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b0, 27'd0, 1'b0},
        '{7'd0,   3'd1, 3'd1, '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b1, 27'd0, 1'b1},
        '{7'd1,   3'd1, 3'd1, '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b1, 27'd0, 1'b0},
        '{7'd10,  3'd2, 3'd2, '{6'd1, 6'd10, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b1, 27'd0, 1'b1},
        '{7'd64,  3'd0, 3'd1, '{6'd42, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b0, 27'd0, 1'b0},
        '{7'd64,  3'd7, 3'd6, '{6'd58, 6'd59, 6'd60, 6'd61, 6'd62, 6'd63},
          1'b1, 27'd74974367, 1'b0},
        '{7'd3,   3'd4, 3'd4, '{6'd0, 6'd1, 6'd2, 6'd2, 6'd0, 6'd0}, 1'b1, 27'd0, 1'b1}
    };

    logic clk;
    logic rst_n;

    cr_cfg_if    cfg_bus ();
    cr_item_if   item_bus ();
    cr_result_if result_bus ();

    combination_rank dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .item   (item_bus),
        .result (result_bus)
    );

    logic [N_W-1:0]    cfg_n = PARAM_COUNT_RST;
    logic [T_W-1:0]    cfg_t = SUBSET_SIZE_RST;
    logic [POS_W-1:0]  last_pos = '0;
    logic [T_W-1:0]    seen_count = '0;
    logic [RANK_W-1:0] partial_rank = '0;
    logic              bad_seen = 1'b0;

    feed_item_t   position_feed [$];
    rank_result_t pending_ranks [$];
    feed_item_t   on_wire;
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           stall_asks = 0;
    int           stall_served = 0;
    int           hold_left = 0;
    bit           calm = 1'b0;

    function automatic longint choose(int x, int m);
        longint v;
        v = 1;
        if (x < 0 || m < 0 || x < m)
            return 0;
        if (m > x / 2)
            m = x - m;
        for (int i = 0; i < m; i++)
            v = v * (x - i) / (1 + i);
        return v;
    endfunction

    function automatic longint column_sum(int base, int m, int k);
        longint s;
        s = 0;
        for (int j = 0; j < k; j++)
            s += choose(base - j, m);
        return s;
    endfunction

    // Folds one position into the subset in progress; done marks a completed subset.
    function automatic void advance_rank(input logic [POS_W-1:0] pos, output bit done,
                                         output rank_result_t res);
        int     n;
        int     t;
        int     c;
        int     p;
        int     pi;
        longint add;
        n = (cfg_n > MAX_POSITIONS_DEF) ? MAX_POSITIONS_DEF : int'(cfg_n);
        t = (cfg_t == 0) ? 1 : ((cfg_t > MAX_SUBSET_DEF) ? MAX_SUBSET_DEF : int'(cfg_t));
        c = int'(seen_count);
        if (c >= t)
            c = t - 1;
        p = int'(last_pos);
        pi = int'(pos);
        if (pi >= n || (c > 0 && pi <= p))
        begin
            bad_seen = 1'b1;
        end
        else
        begin
            if (c == 0)
                add = column_sum(n - 1, t - 1 - c, pi);
            else
                add = column_sum(n - p - 2, t - 1 - c, pi - p - 1);
            partial_rank = partial_rank + add[RANK_W-1:0];
        end
        last_pos = pos;
        res = '0;
        done = 1'b0;
        if (c + 1 >= t)
        begin
            done = 1'b1;
            res.rank = bad_seen ? '0 : partial_rank;
            res.err = bad_seen;
            last_pos = '0;
            seen_count = '0;
            partial_rank = '0;
            bad_seen = 1'b0;
        end
        else
        begin
            seen_count = T_W'(c + 1);
        end
    endfunction

    function automatic void feed_position(logic [POS_W-1:0] pos);
        feed_item_t entry;
        entry = '{position: pos, typed: 1'b0, rank: '0, err: 1'b0};
        position_feed.insert(position_feed.size(), entry);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin : drive_items
        bit           done;
        rank_result_t res;
        if (rst_n)
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                advance_rank(on_wire.position, done, res);
                if (done)
                begin
                    if (on_wire.typed)
                    begin
                        res.rank = on_wire.rank;
                        res.err = on_wire.err;
                    end
                    pending_ranks.insert(pending_ranks.size(), res);
                end
            end
            if (!item_bus.valid || item_bus.ready)
            begin
                if (position_feed.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    on_wire = position_feed.pop_front();
                    item_bus.valid <= 1'b1;
                    item_bus.position <= on_wire.position;
                end
                else
                begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
        else
        begin
            item_bus.valid <= 1'b0;
            item_bus.position <= '0;
        end
    end

    always @(posedge clk)
    begin : check_ranks
        rank_result_t want;
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (pending_ranks.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result rank %0d order_error %0b", $time,
                             result_bus.rank, result_bus.order_error);
                end
                else
                begin
                    want = pending_ranks.pop_front();
                    if (result_bus.rank !== want.rank)
                    begin
                        mismatches++;
                        $display("%0t: rank expected %0d actual %0d", $time, want.rank,
                                 result_bus.rank);
                    end
                    if (result_bus.order_error !== want.err)
                    begin
                        mismatches++;
                        $display("%0t: order_error expected %0b actual %0b", $time, want.err,
                                 result_bus.order_error);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else if (stall_asks != stall_served)
            begin
                stall_served = stall_asks;
                hold_left = HOLD_CYCLES;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
        else
        begin
            result_bus.ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sampled at the falling edge, so that every update of the rising edge has landed.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (position_feed.size() != 0 || item_bus.valid || pending_ranks.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(logic [N_W-1:0] n_val, logic [T_W-1:0] t_val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= REG_PARAM_COUNT;
        cfg_bus.data <= n_val;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_n = n_val;
        cfg_bus.index <= REG_SUBSET_SIZE;
        cfg_bus.data <= CFG_DATA_W'(t_val);
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_t = t_val;
        cfg_bus.valid <= 1'b0;
    endtask

    initial
    begin
        int              random_items;
        int              phase;
        int              subsets;
        int              n_eff;
        int              t_eff;
        int              picked;
        int              k;
        logic [N_W-1:0]  n_val;
        logic [T_W-1:0]  t_val;
        logic [63:0]     chosen;
        rank_case_t      row;
        feed_item_t      entry;

        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_PARAM_COUNT;
        cfg_bus.data = '0;
        random_items = 0;
        phase = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            row = directed_cases[r];
            if (row.n != cfg_n || row.t != cfg_t)
            begin
                wait_idle();
                write_config(row.n, row.t);
            end
            for (int i = 0; i < row.len; i++)
            begin
                entry = '{position: row.pos[i],
                          typed: row.typed && (i == row.len - 1),
                          rank: row.rank, err: row.err};
                position_feed.insert(position_feed.size(), entry);
            end
        end

        while (random_items < RANDOM_ITEMS)
        begin
            phase++;
            case ($urandom_range(9))
                0: n_val = N_W'(MAX_POSITIONS_DEF);
                1: n_val = N_W'($urandom_range(1, 3));
                2: n_val = N_W'($urandom_range(0, 127));
                default: n_val = N_W'($urandom_range(1, MAX_POSITIONS_DEF));
            endcase
            case ($urandom_range(19))
                0: t_val = 3'd0;
                1: t_val = 3'd7;
                default: t_val = T_W'($urandom_range(1, MAX_SUBSET_DEF));
            endcase
            wait_idle();
            write_config(n_val, t_val);
            calm = (phase >= 4 && phase < 8);
            if (phase % 7 == 3)
                stall_asks++;
            n_eff = (n_val > MAX_POSITIONS_DEF) ? MAX_POSITIONS_DEF : int'(n_val);
            t_eff = (t_val == 0) ? 1 :
                    ((t_val > MAX_SUBSET_DEF) ? MAX_SUBSET_DEF : int'(t_val));
            subsets = $urandom_range(4, 16);
            for (int s = 0; s < subsets; s++)
            begin
                if (n_eff >= t_eff && $urandom_range(99) < 85)
                begin
                    chosen = '0;
                    picked = 0;
                    while (picked < t_eff)
                    begin
                        k = int'($urandom_range(n_eff - 1));
                        if (!chosen[k])
                        begin
                            chosen[k] = 1'b1;
                            picked++;
                        end
                    end
                    for (int p = 0; p < n_eff; p++)
                        if (chosen[p])
                            feed_position(POS_W'(p));
                end
                else
                begin
                    for (int i = 0; i < t_eff; i++)
                        feed_position(POS_W'($urandom_range(63)));
                end
                random_items += t_eff;
            end
        end

        wait_idle();
        if (mismatches == 0 && pending_ranks.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
